/* design/chte_pkg.sv */
// Shared constants, types and controller/datapath interface structs.
package chte_pkg;

  localparam int MAX_KNOTS = 8;
  localparam int JOINTS    = 6;
  localparam int KAW       = $clog2(MAX_KNOTS);
  localparam int PV_DEPTH  = MAX_KNOTS * JOINTS;
  localparam int PVAW      = $clog2(PV_DEPTH);
  localparam int KNW       = 4;
  localparam int JW        = 3;
  localparam int ACCW      = 56;
  localparam int KNOTS_RESET = 6;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DUR_RD, ST_DUR_WT, ST_MOD_DIV, ST_MOD_FIX,
    ST_SCAN_RD, ST_SCAN_WT, ST_CUR_RD, ST_CUR_WT, ST_S_DIV, ST_S_FIX,
    ST_POW1, ST_POW2, ST_POW3, ST_POW4, ST_BASIS,
    ST_J_RDA, ST_J_RDB, ST_J_CAPB,
    ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8, ST_M9,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {TA_DUR, TA_NEXT, TA_CUR} taddr_t;

  typedef enum logic [2:0] {
    MS_SS, MS_S2S, MS_B00Q0, MS_B01Q1, MS_B10V0, MS_B11V1, MS_TMPH
  } mul_sel_t;

  typedef enum logic [2:0] {AC_NONE, AC_LOAD30, AC_ADD30, AC_ADD12, AC_TMP30} acc_op_t;

  typedef struct packed {
    taddr_t   taddr;
    logic     dur_cap;
    logic     mod_fix;
    logic     scan_cap;
    logic     cur_cap;
    logic     div_step;
    logic     s_fix;
    logic     s2_cap;
    logic     s3_cap;
    logic     basis_cap;
    logic     pv_b;
    logic     capa;
    logic     capb;
    logic     mul_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     j_clr;
    logic     j_inc;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic scan_more;
    logic j_last;
    logic out_free;
  } dp_stat_t;

endpackage

/* design/chte_in_if.sv */
// Input channel carrying load and evaluate items.
interface chte_in_if;
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [2:0]          knot_index;
  logic [2:0]          joint_index;
  logic [30:0]         knot_time;
  logic signed [31:0]  knot_position;
  logic signed [31:0]  knot_velocity;
  logic signed [31:0]  eval_time;
  modport source (output valid, cmd, knot_index, joint_index, knot_time, knot_position,
                  knot_velocity, eval_time, input ready);
  modport sink (input valid, cmd, knot_index, joint_index, knot_time, knot_position,
                knot_velocity, eval_time, output ready);
endinterface

/* design/chte_out_if.sv */
// Output channel carrying one interpolated joint position per transfer.
interface chte_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         out_joint;
  logic signed [31:0] joint_position;
  logic               last;
  modport source (output valid, out_joint, joint_position, last, input ready);
  modport sink (input valid, out_joint, joint_position, last, output ready);
endinterface

/* design/chte_ram.sv */
// Generic single-port RAM with registered read data.
module chte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* design/chte_ctrl.sv */
// Controller state machine sequencing the evaluation datapath.
module chte_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_cmd,
  input  chte_pkg::dp_stat_t stat,
  output logic              in_ready,
  output chte_pkg::dp_cmd_t cmd
);
  chte_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chte_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      chte_pkg::ST_IDLE: begin
        if (in_valid && in_cmd == chte_pkg::CMD_EVAL) begin
          state_next = chte_pkg::ST_DUR_RD;
        end
      end
      chte_pkg::ST_DUR_RD:  state_next = chte_pkg::ST_DUR_WT;
      chte_pkg::ST_DUR_WT:  state_next = chte_pkg::ST_MOD_DIV;
      chte_pkg::ST_MOD_DIV: if (stat.div_done) begin
        state_next = chte_pkg::ST_MOD_FIX;
      end
      chte_pkg::ST_MOD_FIX: state_next = chte_pkg::ST_SCAN_RD;
      chte_pkg::ST_SCAN_RD: state_next = chte_pkg::ST_SCAN_WT;
      chte_pkg::ST_SCAN_WT: begin
        state_next = stat.scan_more ? chte_pkg::ST_SCAN_RD : chte_pkg::ST_CUR_RD;
      end
      chte_pkg::ST_CUR_RD:  state_next = chte_pkg::ST_CUR_WT;
      chte_pkg::ST_CUR_WT:  state_next = chte_pkg::ST_S_DIV;
      chte_pkg::ST_S_DIV:   if (stat.div_done) begin
        state_next = chte_pkg::ST_S_FIX;
      end
      chte_pkg::ST_S_FIX:   state_next = chte_pkg::ST_POW1;
      chte_pkg::ST_POW1:    state_next = chte_pkg::ST_POW2;
      chte_pkg::ST_POW2:    state_next = chte_pkg::ST_POW3;
      chte_pkg::ST_POW3:    state_next = chte_pkg::ST_POW4;
      chte_pkg::ST_POW4:    state_next = chte_pkg::ST_BASIS;
      chte_pkg::ST_BASIS:   state_next = chte_pkg::ST_J_RDA;
      chte_pkg::ST_J_RDA:   state_next = chte_pkg::ST_J_RDB;
      chte_pkg::ST_J_RDB:   state_next = chte_pkg::ST_J_CAPB;
      chte_pkg::ST_J_CAPB:  state_next = chte_pkg::ST_M1;
      chte_pkg::ST_M1:      state_next = chte_pkg::ST_M2;
      chte_pkg::ST_M2:      state_next = chte_pkg::ST_M3;
      chte_pkg::ST_M3:      state_next = chte_pkg::ST_M4;
      chte_pkg::ST_M4:      state_next = chte_pkg::ST_M5;
      chte_pkg::ST_M5:      state_next = chte_pkg::ST_M6;
      chte_pkg::ST_M6:      state_next = chte_pkg::ST_M7;
      chte_pkg::ST_M7:      state_next = chte_pkg::ST_M8;
      chte_pkg::ST_M8:      state_next = chte_pkg::ST_M9;
      chte_pkg::ST_M9:      state_next = chte_pkg::ST_OUT;
      chte_pkg::ST_OUT: begin
        if (stat.out_free) begin
          state_next = stat.j_last ? chte_pkg::ST_IDLE : chte_pkg::ST_J_RDA;
        end
      end
      default: state_next = chte_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      chte_pkg::ST_IDLE:    in_ready = 1'b1;
      chte_pkg::ST_DUR_RD:  cmd.taddr = chte_pkg::TA_DUR;
      chte_pkg::ST_DUR_WT:  cmd.dur_cap = 1'b1;
      chte_pkg::ST_MOD_DIV: cmd.div_step = !stat.div_done;
      chte_pkg::ST_MOD_FIX: cmd.mod_fix = 1'b1;
      chte_pkg::ST_SCAN_RD: cmd.taddr = chte_pkg::TA_NEXT;
      chte_pkg::ST_SCAN_WT: cmd.scan_cap = 1'b1;
      chte_pkg::ST_CUR_RD:  cmd.taddr = chte_pkg::TA_CUR;
      chte_pkg::ST_CUR_WT:  cmd.cur_cap = 1'b1;
      chte_pkg::ST_S_DIV:   cmd.div_step = !stat.div_done;
      chte_pkg::ST_S_FIX:   cmd.s_fix = 1'b1;
      chte_pkg::ST_POW1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = chte_pkg::MS_SS;
      end
      chte_pkg::ST_POW2:    cmd.s2_cap = 1'b1;
      chte_pkg::ST_POW3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = chte_pkg::MS_S2S;
      end
      chte_pkg::ST_POW4:    cmd.s3_cap = 1'b1;
      chte_pkg::ST_BASIS: begin
        cmd.basis_cap = 1'b1;
        cmd.j_clr     = 1'b1;
      end
      chte_pkg::ST_J_RDA:   cmd.pv_b = 1'b0;
      chte_pkg::ST_J_RDB: begin
        cmd.pv_b = 1'b1;
        cmd.capa = 1'b1;
      end
      chte_pkg::ST_J_CAPB:  cmd.capb = 1'b1;
      chte_pkg::ST_M1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = chte_pkg::MS_B00Q0;
      end
      chte_pkg::ST_M2: begin
        cmd.acc_op  = chte_pkg::AC_LOAD30;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = chte_pkg::MS_B01Q1;
      end
      chte_pkg::ST_M3: begin
        cmd.acc_op  = chte_pkg::AC_ADD30;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = chte_pkg::MS_B10V0;
      end
      chte_pkg::ST_M4:      cmd.acc_op = chte_pkg::AC_TMP30;
      chte_pkg::ST_M5: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = chte_pkg::MS_TMPH;
      end
      chte_pkg::ST_M6: begin
        cmd.acc_op  = chte_pkg::AC_ADD12;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = chte_pkg::MS_B11V1;
      end
      chte_pkg::ST_M7:      cmd.acc_op = chte_pkg::AC_TMP30;
      chte_pkg::ST_M8: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = chte_pkg::MS_TMPH;
      end
      chte_pkg::ST_M9:      cmd.acc_op = chte_pkg::AC_ADD12;
      chte_pkg::ST_OUT: begin
        cmd.out_load = stat.out_free;
        cmd.j_inc    = stat.out_free;
      end
      default: cmd = '0;
    endcase
  end
endmodule

/* design/chte_dp.sv */
// Datapath: knot tables, shared divider, shared multiplier and output register.
module chte_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic                           in_cmd,
  input  logic [2:0]                     knot_index,
  input  logic [2:0]                     joint_index,
  input  logic [30:0]                    knot_time,
  input  logic signed [31:0]             knot_position,
  input  logic signed [31:0]             knot_velocity,
  input  logic signed [31:0]             eval_time,
  input  logic [chte_pkg::KNW-1:0]       knots,
  input  chte_pkg::dp_cmd_t              cmd,
  output chte_pkg::dp_stat_t             stat,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [chte_pkg::JW-1:0]        out_joint,
  output logic signed [31:0]             joint_position,
  output logic                           last
);
  localparam logic signed [chte_pkg::ACCW-1:0] SAT_HI = chte_pkg::ACCW'(64'sd2147483647);
  localparam logic signed [chte_pkg::ACCW-1:0] SAT_LO = chte_pkg::ACCW'(-64'sd2147483648);

  logic                           load_we, pv_we;
  logic [chte_pkg::KAW-1:0]       t_addr;
  logic [30:0]                    t_rdata;
  logic [chte_pkg::PVAW-1:0]      pv_addr, pv_a, pv_w;
  logic [31:0]                    pos_rdata, vel_rdata;
  logic [chte_pkg::KNW-1:0]       n;
  logic [chte_pkg::KAW-1:0]       i;
  logic [chte_pkg::JW-1:0]        j;
  logic                           eneg;
  logic [31:0]                    eabs;
  logic [30:0]                    dur, t, tnext;
  logic [31:0]                    rem, dvd, q;
  logic [30:0]                    dvs;
  logic [5:0]                     cnt;
  logic [32:0]                    sh;
  logic                           qbit;
  logic signed [31:0]             h, d;
  logic                           hpos_c, hpos;
  logic [30:0]                    dcl, hp;
  logic [30:0]                    s, s2, s3;
  logic signed [33:0]             se, s2e, s3e;
  logic signed [33:0]             b00, b10, b01, b11, tmp;
  logic signed [31:0]             q0, q1, v0, v1;
  logic signed [33:0]             mul_a;
  logic signed [32:0]             mul_b;
  logic signed [66:0]             prod, p30, p12;
  logic signed [chte_pkg::ACCW-1:0] acc;

  always_comb begin
    if (knots < chte_pkg::KNW'(2)) begin
      n = chte_pkg::KNW'(2);
    end else if (int'(knots) > chte_pkg::MAX_KNOTS) begin
      n = chte_pkg::KNW'(chte_pkg::MAX_KNOTS);
    end else begin
      n = knots;
    end
  end

  assign load_we = accept && in_cmd == chte_pkg::CMD_LOAD &&
                   int'(knot_index) < chte_pkg::MAX_KNOTS;
  assign pv_we   = load_we && int'(joint_index) < chte_pkg::JOINTS;
  assign pv_w    = chte_pkg::PVAW'(int'(knot_index) * chte_pkg::JOINTS + int'(joint_index));
  assign pv_a    = chte_pkg::PVAW'(int'(i) * chte_pkg::JOINTS + int'(j));
  assign pv_addr = pv_we ? pv_w : (cmd.pv_b ? pv_a + chte_pkg::PVAW'(chte_pkg::JOINTS) : pv_a);

  always_comb begin
    unique case (cmd.taddr)
      chte_pkg::TA_DUR:  t_addr = chte_pkg::KAW'(n - chte_pkg::KNW'(1));
      chte_pkg::TA_NEXT: t_addr = i + chte_pkg::KAW'(1);
      chte_pkg::TA_CUR:  t_addr = i;
      default:           t_addr = i;
    endcase
    if (load_we) begin
      t_addr = chte_pkg::KAW'(knot_index);
    end
  end

  chte_ram #(.WIDTH(31), .DEPTH(chte_pkg::MAX_KNOTS)) u_time (
    .clk(clk), .we(load_we), .addr(t_addr), .wdata(knot_time), .rdata(t_rdata)
  );
  chte_ram #(.WIDTH(32), .DEPTH(chte_pkg::PV_DEPTH)) u_pos (
    .clk(clk), .we(pv_we), .addr(pv_addr), .wdata(knot_position), .rdata(pos_rdata)
  );
  chte_ram #(.WIDTH(32), .DEPTH(chte_pkg::PV_DEPTH)) u_vel (
    .clk(clk), .we(pv_we), .addr(pv_addr), .wdata(knot_velocity), .rdata(vel_rdata)
  );

  assign sh   = {rem, dvd[31]};
  assign qbit = sh >= {2'b00, dvs};
  assign h    = $signed({1'b0, tnext}) - $signed({1'b0, t_rdata});
  assign d    = $signed({1'b0, t}) - $signed({1'b0, t_rdata});
  assign hpos_c = !h[31] && h != 32'sd0;
  always_comb begin
    if (d[31]) begin
      dcl = '0;
    end else if (d > h) begin
      dcl = h[30:0];
    end else begin
      dcl = d[30:0];
    end
  end

  assign stat.div_done  = cnt == 6'd0;
  assign stat.scan_more = int'(i) < int'(n) - 2 && t >= t_rdata;
  assign stat.j_last    = int'(j) == chte_pkg::JOINTS - 1;
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.dur_cap) begin
      cnt <= 6'd32;
    end else if (cmd.cur_cap) begin
      cnt <= 6'd31;
    end else if (cmd.div_step) begin
      cnt <= cnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      eneg <= eval_time[31];
      eabs <= eval_time[31] ? 32'(-eval_time) : eval_time;
    end
    if (cmd.dur_cap) begin
      dur <= t_rdata;
      rem <= '0;
      dvd <= eabs;
      dvs <= t_rdata;
      i   <= '0;
    end
    if (cmd.div_step) begin
      rem <= qbit ? 32'(sh - {2'b00, dvs}) : sh[31:0];
      dvd <= {dvd[30:0], 1'b0};
      q   <= {q[30:0], qbit};
    end
    if (cmd.mod_fix) begin
      if (dur == '0) begin
        t <= '0;
      end else if (eneg && rem != '0) begin
        t <= dur - rem[30:0];
      end else begin
        t <= rem[30:0];
      end
    end
    if (cmd.scan_cap) begin
      if (stat.scan_more) begin
        i <= i + chte_pkg::KAW'(1);
      end else begin
        tnext <= t_rdata;
      end
    end
    if (cmd.cur_cap) begin
      hpos <= hpos_c;
      hp   <= hpos_c ? h[30:0] : '0;
      dvs  <= h[30:0];
      rem  <= hpos_c ? {2'b00, dcl[30:1]} : '0;
      dvd  <= {hpos_c & dcl[0], 31'b0};
    end
    if (cmd.s_fix) begin
      s <= hpos ? q[30:0] : '0;
    end
    if (cmd.s2_cap) begin
      s2 <= prod[60:30];
    end
    if (cmd.s3_cap) begin
      s3 <= prod[60:30];
    end
    if (cmd.basis_cap) begin
      b00 <= 34'sd2 * s3e - 34'sd3 * s2e + 34'sd1073741824;
      b10 <= s3e - 34'sd2 * s2e + se;
      b01 <= 34'sd3 * s2e - 34'sd2 * s3e;
      b11 <= s3e - s2e;
    end
    if (cmd.capa) begin
      q0 <= pos_rdata;
      v0 <= vel_rdata;
    end
    if (cmd.capb) begin
      q1 <= pos_rdata;
      v1 <= vel_rdata;
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    unique case (cmd.acc_op)
      chte_pkg::AC_LOAD30: acc <= $signed(p30[chte_pkg::ACCW-1:0]);
      chte_pkg::AC_ADD30:  acc <= acc + $signed(p30[chte_pkg::ACCW-1:0]);
      chte_pkg::AC_ADD12:  acc <= acc + $signed(p12[chte_pkg::ACCW-1:0]);
      chte_pkg::AC_TMP30:  tmp <= $signed(p30[33:0]);
      chte_pkg::AC_NONE:   acc <= acc;
      default:             acc <= acc;
    endcase
  end

  assign se  = $signed({3'b000, s});
  assign s2e = $signed({3'b000, s2});
  assign s3e = $signed({3'b000, s3});
  assign p30 = prod >>> 30;
  assign p12 = prod >>> 12;

  always_comb begin
    unique case (cmd.mul_sel)
      chte_pkg::MS_SS: begin
        mul_a = se;
        mul_b = $signed({2'b00, s});
      end
      chte_pkg::MS_S2S: begin
        mul_a = s2e;
        mul_b = $signed({2'b00, s});
      end
      chte_pkg::MS_B00Q0: begin
        mul_a = b00;
        mul_b = 33'(q0);
      end
      chte_pkg::MS_B01Q1: begin
        mul_a = b01;
        mul_b = 33'(q1);
      end
      chte_pkg::MS_B10V0: begin
        mul_a = b10;
        mul_b = 33'(v0);
      end
      chte_pkg::MS_B11V1: begin
        mul_a = b11;
        mul_b = 33'(v1);
      end
      chte_pkg::MS_TMPH: begin
        mul_a = tmp;
        mul_b = $signed({2'b00, hp});
      end
      default: begin
        mul_a = se;
        mul_b = $signed({2'b00, s});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j <= '0;
    end else if (cmd.j_clr) begin
      j <= '0;
    end else if (cmd.j_inc) begin
      j <= j + chte_pkg::JW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_joint <= j;
      last      <= stat.j_last;
      if (acc > SAT_HI) begin
        joint_position <= 32'sh7FFFFFFF;
      end else if (acc < SAT_LO) begin
        joint_position <= 32'sh80000000;
      end else begin
        joint_position <= acc[31:0];
      end
    end
  end
endmodule

/* design/cubic_hermite_trajectory_eval.sv */
// Top level of the cubic Hermite trajectory evaluator.
// Items arrive on in_ch as valid/ready transfers. A load item (cmd 0) writes one
// knot time and one joint's position and velocity, and produces nothing. An
// evaluate item (cmd 1) produces one transfer per joint on out_ch, joint 0
// first, with last set on the final joint.
// A load does not leave the idle state. An evaluation runs a 32-step remainder
// and a 31-step offset division on one shared radix-2 divider, a linear
// segment scan through the time table's read port, and the per-joint products
// on one shared multiplier.
// The next item is accepted once the last joint has entered the output
// register, even while that result is still waiting.
// A stalled receiver holds the output register; the controller then waits
// before loading the next joint. Reset clears control state and sets
// knots_in_use to 6; the knot tables are undefined until loaded.
// knots_in_use is written over the APB port at address 0; the user must do
// so only while idle, as the block itself does not enforce it.
module cubic_hermite_trajectory_eval (
  input  logic        clk,
  input  logic        rst,
  chte_in_if.sink     in_ch,
  chte_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic                     knots_wr;
  logic [chte_pkg::KNW-1:0] knots_in_use;
  logic                     accept;
  chte_pkg::dp_cmd_t        cmd;
  chte_pkg::dp_stat_t       stat;

  assign pready   = 1'b1;
  assign knots_wr = psel && penable && pwrite && pready && paddr == 2'd0;
  assign prdata   = {{(32 - chte_pkg::KNW){1'b0}}, knots_in_use};

  always_ff @(posedge clk) begin
    if (rst) begin
      knots_in_use <= chte_pkg::KNW'(chte_pkg::KNOTS_RESET);
    end else if (knots_wr) begin
      knots_in_use <= pwdata[chte_pkg::KNW-1:0];
    end
  end

  assign accept = in_ch.valid && in_ch.ready;

  chte_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_cmd(in_ch.cmd),
    .stat(stat), .in_ready(in_ch.ready), .cmd(cmd)
  );

  chte_dp u_dp (
    .clk(clk), .rst(rst), .accept(accept), .in_cmd(in_ch.cmd),
    .knot_index(in_ch.knot_index), .joint_index(in_ch.joint_index),
    .knot_time(in_ch.knot_time), .knot_position(in_ch.knot_position),
    .knot_velocity(in_ch.knot_velocity), .eval_time(in_ch.eval_time),
    .knots(knots_in_use), .cmd(cmd), .stat(stat),
    .out_ready(out_ch.ready), .out_valid(out_ch.valid), .out_joint(out_ch.out_joint),
    .joint_position(out_ch.joint_position), .last(out_ch.last)
  );
endmodule
